>>> rtl/axrot_pkg.sv
// ----------------------------------------------------------------------------
// axrot_pkg
// Shared types, codes and the sine table builder for the 3D point rotator.
// ----------------------------------------------------------------------------
package axrot_pkg;

  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned AngleW     = 16;

  localparam int unsigned QuarterTurn = 90;
  localparam int unsigned HalfTurn    = 180;
  localparam int unsigned FullTurn    = 360;

  // non-negative bias for the angle reduction: 92 full turns
  localparam int unsigned AngleBias   = 33120;
  localparam int unsigned ReduceW     = 17;
  localparam int unsigned ReduceSteps = 8;

  localparam int unsigned TabLast     = 90;
  localparam int unsigned TabEntryW   = 26;
  localparam logic [63:0] PiQ30       = 64'd3373259426;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AXIS  = 4'd0,
    REG_ANGLE = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_PASS = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_REDUCE,
    TRIG_LOOKUP
  } trig_state_e;

  typedef logic [TabLast:0][TabEntryW-1:0] sin_tab_t;

  // sin(k deg), k = 0..90: Taylor series in unsigned Q30, rounded to frac_bits
  function automatic sin_tab_t build_sin_tab(int unsigned frac_bits);
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      rnd;
    tab = '0;
    for (int unsigned k = 0; k <= TabLast; k++) begin
      x    = (64'(k) * PiQ30) / HalfTurn;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int unsigned n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rnd    = (sum + (longint'(1) <<< (29 - frac_bits))) >>> (30 - frac_bits);
      tab[k] = rnd[TabEntryW-1:0];
    end
    return tab;
  endfunction

endpackage

>>> rtl/axis_rotation_3d_point.sv
// ----------------------------------------------------------------------------
// axis_rotation_3d_point
// Rotates Q15.8 points about the X, Y or Z axis by a whole-degree angle.
// ----------------------------------------------------------------------------
// Pipeline: four register stages (operands, partial products, sum, result).
// Throughput: one point per cycle unless output stall or angle reload holds input.
// An angle write holds off input while sine and cosine reload
// (8 reduction steps and one table lookup).
// Reset: axis X, angle 0 (cosine 1, sine 0), pipeline empty.
// ----------------------------------------------------------------------------
module axis_rotation_3d_point #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // x_in, y_in, z_in
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // x_out, y_out, z_out
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // saturated
  output logic [0:0]                              m_axis_tuser,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [axrot_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [axrot_pkg::CfgDataW-1:0]          cfg_data_i
);
  import axrot_pkg::*;

  localparam int unsigned W         = COORD_WIDTH;
  localparam int unsigned CoefW     = TRIG_FRAC_BITS + 2;
  localparam int unsigned TdataW    = ((3 * W + 7) / 8) * 8;
  localparam int unsigned NumStages = 4;
  localparam int unsigned NumLanes  = 3;

  axis_e                   axis_q;
  logic                    trig_busy;
  logic                    trig_load;
  logic                    cfg_fire;
  logic signed [CoefW-1:0] sin_v, cos_v, neg_sin, one_v;
  logic [NumStages-1:0]    v_q, v_d, adv;
  logic                    s_fire;
  logic signed [W-1:0]     x_in, y_in, z_in;
  logic signed [W-1:0]     lane_a [NumLanes];
  logic signed [W-1:0]     lane_b [NumLanes];
  logic signed [CoefW-1:0] lane_ca [NumLanes];
  logic signed [CoefW-1:0] lane_cb [NumLanes];
  logic signed [W-1:0]     lane_res [NumLanes];
  logic [NumLanes-1:0]     lane_sat;

  assign cfg_ready_o = !trig_busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign trig_load   = cfg_fire && (cfg_index_i == REG_ANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_X;
    end else if (cfg_fire && (cfg_index_i == REG_AXIS)) begin
      axis_q <= axis_e'(cfg_data_i[1:0]);
    end
  end

  axrot_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (trig_load),
    .angle_i(cfg_data_i[AngleW-1:0]),
    .busy_o (trig_busy),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  always_comb begin
    adv[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0] && !trig_busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    v_d = v_q;
    if (adv[0]) begin
      v_d[0] = s_fire;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign x_in    = s_axis_tdata[W-1:0];
  assign y_in    = s_axis_tdata[2*W-1:W];
  assign z_in    = s_axis_tdata[3*W-1:2*W];
  assign neg_sin = -sin_v;
  assign one_v   = CoefW'(1) << TRIG_FRAC_BITS;

  always_comb begin
    lane_a[0]  = x_in;  lane_ca[0] = one_v;  lane_b[0] = x_in;  lane_cb[0] = '0;
    lane_a[1]  = y_in;  lane_ca[1] = one_v;  lane_b[1] = y_in;  lane_cb[1] = '0;
    lane_a[2]  = z_in;  lane_ca[2] = one_v;  lane_b[2] = z_in;  lane_cb[2] = '0;
    unique case (axis_q)
      AXIS_X: begin
        lane_ca[1] = cos_v;  lane_b[1] = z_in;  lane_cb[1] = sin_v;
        lane_ca[2] = cos_v;  lane_b[2] = y_in;  lane_cb[2] = neg_sin;
      end
      AXIS_Y: begin
        lane_ca[0] = cos_v;  lane_b[0] = z_in;  lane_cb[0] = neg_sin;
        lane_a[2]  = x_in;   lane_ca[2] = sin_v;
        lane_b[2]  = z_in;   lane_cb[2] = cos_v;
      end
      AXIS_Z: begin
        lane_ca[0] = cos_v;  lane_b[0] = y_in;  lane_cb[0] = sin_v;
        lane_ca[1] = cos_v;  lane_b[1] = x_in;  lane_cb[1] = neg_sin;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    axrot_mac #(
      .COORD_WIDTH   (COORD_WIDTH),
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_mac (
      .clk_i(clk_i),
      .en_i (adv),
      .a_i  (lane_a[i]),
      .ca_i (lane_ca[i]),
      .b_i  (lane_b[i]),
      .cb_i (lane_cb[i]),
      .res_o(lane_res[i]),
      .sat_o(lane_sat[i])
    );
  end

  assign m_axis_tvalid = v_q[NumStages-1];
  assign m_axis_tdata  = TdataW'({lane_res[2], lane_res[1], lane_res[0]});
  assign m_axis_tuser  = |lane_sat;

endmodule

>>> rtl/axrot_trig.sv
// ----------------------------------------------------------------------------
// axrot_trig
// Angle register path: reduces a signed degree angle modulo 360 by restoring
// subtraction, then looks up sine and cosine with quadrant folding.
// ----------------------------------------------------------------------------
module axrot_trig #(
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic        [axrot_pkg::AngleW-1:0]    angle_i,
  output logic                                   busy_o,
  output logic signed [TRIG_FRAC_BITS+1:0]       sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]       cos_o
);
  import axrot_pkg::*;

  localparam int unsigned CoefW = TRIG_FRAC_BITS + 2;
  localparam sin_tab_t SinTab = build_sin_tab(TRIG_FRAC_BITS);

  trig_state_e               state_q, state_d;
  logic [ReduceW-1:0]        acc_q, acc_d;
  logic [2:0]                step_q, step_d;
  logic signed [CoefW-1:0]   sin_q, sin_d;
  logic signed [CoefW-1:0]   cos_q, cos_d;

  logic [ReduceW-1:0]        limit;
  logic [8:0]                ang;
  logic [8:0]                rel;
  logic [6:0]                r_idx;
  logic [6:0]                rc_idx;
  logic signed [CoefW-1:0]   s_mag;
  logic signed [CoefW-1:0]   c_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      step_q  <= '0;
      acc_q   <= '0;
      sin_q   <= '0;
      cos_q   <= CoefW'(1) << TRIG_FRAC_BITS;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      acc_q   <= acc_d;
      sin_q   <= sin_d;
      cos_q   <= cos_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    acc_d   = acc_q;
    sin_d   = sin_q;
    cos_d   = cos_q;
    limit   = ReduceW'(FullTurn) << step_q;
    ang     = acc_q[8:0];
    rel     = ang;
    if (ang >= 9'(3 * QuarterTurn)) begin
      rel = ang - 9'(3 * QuarterTurn);
    end else if (ang >= 9'(HalfTurn)) begin
      rel = ang - 9'(HalfTurn);
    end else if (ang >= 9'(QuarterTurn)) begin
      rel = ang - 9'(QuarterTurn);
    end
    r_idx  = rel[6:0];
    rc_idx = 7'(QuarterTurn) - r_idx;
    s_mag  = SinTab[r_idx][CoefW-1:0];
    c_mag  = SinTab[rc_idx][CoefW-1:0];

    unique case (state_q)
      TRIG_IDLE: begin
        if (load_i) begin
          acc_d   = {angle_i[AngleW-1], angle_i} + ReduceW'(AngleBias);
          step_d  = 3'(ReduceSteps - 1);
          state_d = TRIG_REDUCE;
        end
      end
      TRIG_REDUCE: begin
        if (acc_q >= limit) begin
          acc_d = acc_q - limit;
        end
        if (step_q == '0) begin
          state_d = TRIG_LOOKUP;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      TRIG_LOOKUP: begin
        if (ang >= 9'(3 * QuarterTurn)) begin
          sin_d = -c_mag;
          cos_d = s_mag;
        end else if (ang >= 9'(HalfTurn)) begin
          sin_d = -s_mag;
          cos_d = -c_mag;
        end else if (ang >= 9'(QuarterTurn)) begin
          sin_d = c_mag;
          cos_d = -s_mag;
        end else begin
          sin_d = s_mag;
          cos_d = c_mag;
        end
        state_d = TRIG_IDLE;
      end
      default: begin
        state_d = TRIG_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != TRIG_IDLE);
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

>>> rtl/axrot_mac.sv
// ----------------------------------------------------------------------------
// axrot_mac
// Four-stage lane computing round(a*ca + b*cb) >> frac, then saturating.
// Each coordinate is split in halves so every multiplier stays narrow.
// ----------------------------------------------------------------------------
module axrot_mac #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic        [3:0]                 en_i,
  input  logic signed [COORD_WIDTH-1:0]     a_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  ca_i,
  input  logic signed [COORD_WIDTH-1:0]     b_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cb_i,
  output logic signed [COORD_WIDTH-1:0]     res_o,
  output logic                              sat_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned CoefW = TRIG_FRAC_BITS + 2;
  localparam int unsigned LoW   = W / 2;
  localparam int unsigned HiW   = W - LoW;
  localparam int unsigned LoPW  = LoW + 1 + CoefW;
  localparam int unsigned HiPW  = HiW + CoefW;
  localparam int unsigned SumW  = W + CoefW + 1;
  localparam int unsigned QW    = SumW - TRIG_FRAC_BITS;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) << (TRIG_FRAC_BITS - 1);

  logic signed [W-1:0]     a_q, b_q;
  logic signed [CoefW-1:0] ca_q, cb_q;
  logic signed [LoPW-1:0]  pal_d, pal_q, pbl_d, pbl_q;
  logic signed [HiPW-1:0]  pah_d, pah_q, pbh_d, pbh_q;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic signed [QW-1:0]    quo;
  logic [QW-W:0]           top_bits;
  logic                    ovf;
  logic signed [W-1:0]     res_d, res_q;
  logic                    sat_d, sat_q;

  always_comb begin
    pal_d = $signed({1'b0, a_q[LoW-1:0]}) * ca_q;
    pbl_d = $signed({1'b0, b_q[LoW-1:0]}) * cb_q;
    pah_d = $signed(a_q[W-1:LoW]) * ca_q;
    pbh_d = $signed(b_q[W-1:LoW]) * cb_q;
  end

  always_comb begin
    sum_d = ((SumW'(pah_q) + SumW'(pbh_q)) <<< LoW)
          + SumW'(pal_q) + SumW'(pbl_q) + RoundHalf;
  end

  always_comb begin
    quo      = QW'(sum_q >>> TRIG_FRAC_BITS);
    top_bits = quo[QW-1:W-1];
    ovf      = !((&top_bits) || (~|top_bits));
    sat_d    = ovf;
    if (!ovf) begin
      res_d = quo[W-1:0];
    end else if (quo[QW-1]) begin
      res_d = {1'b1, {(W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q  <= a_i;
      b_q  <= b_i;
      ca_q <= ca_i;
      cb_q <= cb_i;
    end
    if (en_i[1]) begin
      pal_q <= pal_d;
      pbl_q <= pbl_d;
      pah_q <= pah_d;
      pbh_q <= pbh_d;
    end
    if (en_i[2]) begin
      sum_q <= sum_d;
    end
    if (en_i[3]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

>>> rtl/axrot_checker.sv
// ----------------------------------------------------------------------------
// axrot_checker
// Port-level checks for the 3D point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module axrot_checker #(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input logic [0:0]                           m_axis_tuser,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o,
  input logic [axrot_pkg::CfgIdxW-1:0]        cfg_index_i
);
  import axrot_pkg::*;

  localparam int unsigned FracBits = TRIG_FRAC_BITS;

  logic angle_fire;
  assign angle_fire = cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_ANGLE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  a_angle_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_fire |=> !s_axis_tready && !cfg_ready_o)
    else $error("input taken during sine/cosine reload");

  a_cfg_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> !s_axis_tready)
    else $error("input ready while trig unit busy");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> (FracBits >= 8) && (FracBits <= 24))
    else $error("trig fraction width out of range");

endmodule

bind axis_rotation_3d_point axrot_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
) u_axrot_checker (.*);
